// ===== rtl/core/sim3264_pkg.sv =====
// ----------------------------------------------------------------------------
// sim3264_pkg: shared types and constants
// Word types, key schedule constants and round helpers for the Simon 32/64
// cipher unit.
// ----------------------------------------------------------------------------
package sim3264_pkg;

    localparam int unsigned WORD_W      = 16;
    localparam int unsigned ROUND_COUNT = 32;
    localparam int unsigned KEY_WORDS   = 4;
    localparam int unsigned KEY_AW      = $clog2(ROUND_COUNT);
    localparam int unsigned CFG_AW      = $clog2(KEY_WORDS);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [KEY_AW-1:0] round_idx_t;
    typedef logic [CFG_AW-1:0] cfg_idx_t;

    localparam round_idx_t ROUND_LAST = round_idx_t'(ROUND_COUNT - 1);
    localparam round_idx_t ROUND_KEYS = round_idx_t'(KEY_WORDS);

    // Reset values of the four key words.
    localparam word_t KEY_RESET [KEY_WORDS] = '{16'h1918, 16'h1110, 16'h0908, 16'h0100};

    // Key schedule constant and the z0 sequence, bit n used for round key n + 4.
    localparam word_t       KS_CONST = 16'hfffc;
    localparam logic [63:0] Z0_SEQ   = 64'h19C3522FB386A45F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // Configuration write, forwarded from the top level to the key unit.
    typedef struct packed {
        logic     wen;
        cfg_idx_t index;
        word_t    data;
    } key_cfg_t;

    function automatic word_t rotl(input word_t v, input int unsigned n);
        rotl = word_t'((v << n) | (v >> (WORD_W - n)));
    endfunction

    function automatic word_t rotr(input word_t v, input int unsigned n);
        rotr = word_t'((v >> n) | (v << (WORD_W - n)));
    endfunction

    function automatic word_t round_f(input word_t x);
        round_f = (rotl(x, 1) & rotl(x, 8)) ^ rotl(x, 2);
    endfunction

endpackage

// ===== rtl/core/sim3264_req_if.sv =====
// ----------------------------------------------------------------------------
// sim3264_req_if: request channel
// Carries one block and its encrypt or decrypt flag under valid and ready.
// ----------------------------------------------------------------------------
interface sim3264_req_if;
    import sim3264_pkg::*;

    logic  valid;
    logic  ready;
    logic  req_type;
    word_t block_left;
    word_t block_right;

    modport source (output valid, output req_type, output block_left,
                    output block_right, input ready);
    modport sink   (input valid, input req_type, input block_left,
                    input block_right, output ready);
endinterface

// ===== rtl/core/sim3264_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sim3264_rsp_if: result channel
// Carries one processed block under valid and ready.
// ----------------------------------------------------------------------------
interface sim3264_rsp_if;
    import sim3264_pkg::*;

    logic  valid;
    logic  ready;
    word_t out_left;
    word_t out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

// ===== rtl/core/simon32_64_block_cipher_unit.sv =====
// An accepted item passes through the prepare, round and drain states to its result
// register, and waits longer while that register still holds an earlier result. A
// new item is taken only once the previous result has been loaded; the single round
// unit runs one Feistel round per cycle, with the round key read from a registered table one round ahead.
// Reset restores the default key and then refills the round key table, as does
// every key write; no item is accepted during that refill.
// ----------------------------------------------------------------------------
// simon32_64_block_cipher_unit: Simon 32/64 encrypt and decrypt
// Round-iterative cipher core with a precomputed round key table.
// ----------------------------------------------------------------------------
module simon32_64_block_cipher_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    sim3264_req_if.sink           req,
    sim3264_rsp_if.source         rsp,
    input  logic                  cfg_wen,
    input  sim3264_pkg::cfg_idx_t cfg_index,
    input  sim3264_pkg::word_t    cfg_wdata
);
    import sim3264_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    round_idx_t round_reg;
    round_idx_t round_next;
    round_idx_t round_inc;
    round_idx_t rd_addr;
    logic       dec_reg;
    logic       dec_next;
    word_t      x_reg;
    word_t      x_next;
    word_t      y_reg;
    word_t      y_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    word_t      out_left_reg;
    word_t      out_left_next;
    word_t      out_right_reg;
    word_t      out_right_next;
    word_t      rd_key;
    logic       key_busy;
    logic       accept;
    logic       slot_free;
    logic       load_out;
    key_cfg_t   key_cfg;

    assign key_cfg = '{wen: cfg_wen, index: cfg_index, data: cfg_wdata};

    sim3264_key_sched u_key_sched (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (key_cfg),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .busy    (key_busy)
    );

    assign accept    = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign round_inc = round_reg + round_idx_t'(1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_PREP;
            ST_PREP:  state_next = ST_RUN;
            ST_RUN:   if (round_reg == ROUND_LAST) state_next = ST_DRAIN;
            ST_DRAIN: if (slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer and the round datapath.
    always_comb begin
        req.ready  = 1'b0;
        rd_addr    = '0;
        round_next = round_reg;
        dec_next   = dec_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                req.ready = !key_busy && !cfg_wen;
                if (accept) begin
                    dec_next   = req.req_type;
                    round_next = '0;
                    // Decryption runs on the swapped block.
                    x_next = req.req_type ? req.block_right : req.block_left;
                    y_next = req.req_type ? req.block_left : req.block_right;
                end
            end
            ST_PREP: begin
                rd_addr = dec_reg ? ROUND_LAST : '0;
            end
            ST_RUN: begin
                rd_addr    = dec_reg ? (ROUND_LAST - round_inc) : round_inc;
                x_next     = round_f(x_reg) ^ y_reg ^ rd_key;
                y_next     = x_reg;
                round_next = round_inc;
            end
            ST_DRAIN: begin
                load_out = slot_free;
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = load_out || (out_valid_reg && !rsp.ready);
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        if (load_out) begin
            out_left_next  = dec_reg ? y_reg : x_reg;
            out_right_next = dec_reg ? x_reg : y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        dec_reg       <= dec_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_left  = out_left_reg;
    assign rsp.out_right = out_right_reg;

`ifndef SYNTHESIS
    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_PREP)
        else $error("accepted item did not start the round sequence");

    a_last_round_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && round_reg == ROUND_LAST) |=> state_reg == ST_DRAIN)
        else $error("round sequence did not end after the last round");

    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg) == ST_DRAIN)
        else $error("result appeared without a finished round sequence");

    a_no_accept_in_refill: assert property (@(posedge clk) disable iff (!rst_n)
        key_busy |-> !accept)
        else $error("item accepted while the round key table was refilling");
`endif

endmodule

// ===== rtl/core/sim3264_key_sched.sv =====
// ----------------------------------------------------------------------------
// sim3264_key_sched: key registers and round key table
// Holds the four key words and expands them into a 32-entry round key table, one
// key per cycle while no key write arrives, after reset and after every key write.
// ----------------------------------------------------------------------------
module sim3264_key_sched (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sim3264_pkg::key_cfg_t   cfg,
    input  sim3264_pkg::round_idx_t rd_addr,
    output sim3264_pkg::word_t      rd_key,
    output logic                    busy
);
    import sim3264_pkg::*;

    word_t      key_word_reg [KEY_WORDS];
    word_t      win_reg      [KEY_WORDS];
    word_t      key_mem      [ROUND_COUNT];
    word_t      rd_key_reg;
    logic       busy_reg;
    logic       busy_next;
    round_idx_t idx_reg;
    round_idx_t idx_next;
    round_idx_t z_idx;
    word_t      t1;
    word_t      t2;
    word_t      sched_key;
    word_t      new_key;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                key_word_reg[i] <= KEY_RESET[i];
            end
        end else if (cfg.wen) begin
            key_word_reg[cfg.index] <= cfg.data;
        end
    end

    // Expansion from the window of the last four keys.
    always_comb begin
        z_idx     = idx_reg - ROUND_KEYS;
        t1        = rotr(win_reg[3], 3) ^ win_reg[1];
        t2        = t1 ^ rotr(t1, 1);
        sched_key = win_reg[0] ^ t2 ^ KS_CONST ^ word_t'(Z0_SEQ[{1'b0, z_idx}]);
        if (idx_reg < ROUND_KEYS) begin
            new_key = key_word_reg[idx_reg[CFG_AW-1:0]];
        end else begin
            new_key = sched_key;
        end
    end

    // A key write restarts the sweep from the first entry.
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (cfg.wen) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (busy_reg) begin
            idx_next = idx_reg + round_idx_t'(1);
            if (idx_reg == ROUND_LAST) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk) begin
        if (busy_reg && !cfg.wen) begin
            key_mem[idx_reg] <= new_key;
            win_reg[0]       <= win_reg[1];
            win_reg[1]       <= win_reg[2];
            win_reg[2]       <= win_reg[3];
            win_reg[3]       <= new_key;
        end
        rd_key_reg <= key_mem[rd_addr];
    end

    assign rd_key = rd_key_reg;
    assign busy   = busy_reg;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Simon 32/64 cipher unit
// Drives encrypt and decrypt items through the request channel under random
// idling and back-pressure, reloads the key between phases, and compares
// every result with a behavioral Simon 32/64 model kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import sim3264_pkg::word_t;
    import sim3264_pkg::cfg_idx_t;

    localparam int  ROUNDS      = 32;
    localparam int  WATCH_LIMIT = 3000;
    localparam int  TAIL_CYCLES = 40;
    localparam int  STALL_LEN   = 300;
    localparam word_t       KS_TAIL = 16'hfffc;
    localparam logic [63:0] Z0_BITS = 64'h19C3522FB386A45F;

    typedef enum logic [1:0] {
        REG_KEY0,
        REG_KEY1,
        REG_KEY2,
        REG_KEY3
    } key_reg_t;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } cipher_op_t;

    typedef struct packed {
        word_t left;
        word_t right;
    } block_t;

    logic     clk;
    logic     rst_n;
    logic     cfg_wen;
    cfg_idx_t cfg_index;
    word_t    cfg_wdata;

    sim3264_req_if req_ch ();
    sim3264_rsp_if rsp_ch ();

    simon32_64_block_cipher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    word_t  key_copy [4] = '{16'h1918, 16'h1110, 16'h0908, 16'h0100};
    block_t pending_blocks [$];
    int     fail_count   = 0;
    int     src_idle_pct = 8;
    int     rcv_idle_pct = 69;
    int     stall_left   = 0;
    int     quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic word_t rot_left(input word_t v, input int n);
        return word_t'({v, v} >> (16 - n));
    endfunction

    function automatic word_t rot_right(input word_t v, input int n);
        return word_t'({v, v} >> n);
    endfunction

    // Behavioral Simon 32/64 under the bench's copy of the key.
    function automatic block_t simon_cipher(input cipher_op_t op, input word_t left,
                                            input word_t right);
        word_t rk [ROUNDS];
        word_t x;
        word_t y;
        word_t t;
        word_t k;
        for (int i = 0; i < 4; i++)
        begin
            rk[i] = key_copy[i];
        end
        for (int i = 4; i < ROUNDS; i++)
        begin
            t = rot_right(rk[i-1], 3) ^ rk[i-3];
            t = t ^ rot_right(t, 1);
            rk[i] = rk[i-4] ^ t ^ KS_TAIL ^ word_t'(Z0_BITS[(i - 4) % 62]);
        end
        // Decryption runs the same rounds on swapped halves with reversed keys.
        x = (op == OP_DECRYPT) ? right : left;
        y = (op == OP_DECRYPT) ? left : right;
        for (int i = 0; i < ROUNDS; i++)
        begin
            k = (op == OP_DECRYPT) ? rk[ROUNDS-1-i] : rk[i];
            t = ((rot_left(x, 1) & rot_left(x, 8)) ^ rot_left(x, 2)) ^ y ^ k;
            y = x;
            x = t;
        end
        if (op == OP_DECRYPT)
            return '{left: y, right: x};
        return '{left: x, right: y};
    endfunction

    // Offers one item with random idle cycles ahead of it; valid stays high
    // afterwards so back-to-back items need no extra edge.
    task automatic send_block(input cipher_op_t op, input word_t left, input word_t right,
                              output block_t result);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= op;
        req_ch.block_left  <= left;
        req_ch.block_right <= right;
        do
            @(posedge clk);
        while (!req_ch.ready);
        result = simon_cipher(op, left, right);
        pending_blocks.push_back(result);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_key_reg(input key_reg_t idx, input word_t value);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= cfg_idx_t'(idx);
        cfg_wdata <= value;
        key_copy[idx] = value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic load_key(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
        wait_drained();
        write_key_reg(REG_KEY0, k0);
        write_key_reg(REG_KEY1, k1);
        write_key_reg(REG_KEY2, k2);
        write_key_reg(REG_KEY3, k3);
    endtask

    // Field extremes and bit patterns under the reset key, both directions,
    // plus a few encrypt-then-decrypt round trips.
    task automatic test_reset_key_patterns();
        word_t  lefts  [8] = '{16'h0000, 16'hffff, 16'h0000, 16'hffff,
                               16'h8000, 16'h0001, 16'haaaa, 16'h6565};
        word_t  rights [8] = '{16'h0000, 16'hffff, 16'hffff, 16'h0000,
                               16'h0001, 16'h8000, 16'h5555, 16'h6877};
        block_t res;
        block_t ct;
        for (int i = 0; i < 8; i++)
            send_block(OP_ENCRYPT, lefts[i], rights[i], res);
        for (int i = 0; i < 4; i++)
            send_block(OP_DECRYPT, lefts[i], rights[i], res);
        for (int i = 0; i < 2; i++)
        begin
            send_block(OP_ENCRYPT, word_t'($urandom), word_t'($urandom), ct);
            send_block(OP_DECRYPT, ct.left, ct.right, res);
        end
    endtask

    // All-zero and all-one keys, then a write to a single key word.
    task automatic test_key_extremes();
        block_t ct;
        block_t res;
        load_key(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_block(OP_ENCRYPT, 16'h0000, 16'h0000, ct);
        send_block(OP_DECRYPT, ct.left, ct.right, res);
        send_block(OP_ENCRYPT, 16'hffff, 16'hffff, res);
        load_key(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_block(OP_ENCRYPT, 16'hffff, 16'hffff, ct);
        send_block(OP_DECRYPT, ct.left, ct.right, res);
        send_block(OP_DECRYPT, 16'h0000, 16'h0000, res);
        wait_drained();
        write_key_reg(REG_KEY2, 16'h8001);
        send_block(OP_ENCRYPT, 16'h1234, 16'h5678, ct);
        send_block(OP_DECRYPT, ct.left, ct.right, res);
    endtask

    // Random items under a fresh random key. Some items decrypt the previous
    // ciphertext so that the decrypt path sees real round trips.
    task automatic test_random_traffic(input int count, input int src_pct, input int rcv_pct);
        block_t last_ct;
        block_t res;
        load_key(word_t'($urandom), word_t'($urandom), word_t'($urandom), word_t'($urandom));
        src_idle_pct = src_pct;
        rcv_idle_pct = rcv_pct;
        send_block(OP_ENCRYPT, word_t'($urandom), word_t'($urandom), last_ct);
        for (int i = 1; i < count; i++)
        begin
            if ($urandom_range(99) < 30)
                send_block(OP_DECRYPT, last_ct.left, last_ct.right, res);
            else if ($urandom_range(1) == 0)
                send_block(OP_ENCRYPT, word_t'($urandom), word_t'($urandom), last_ct);
            else
                send_block(OP_DECRYPT, word_t'($urandom), word_t'($urandom), res);
            // Now and then the sender pauses until the block has emptied.
            if ($urandom_range(99) < 3)
                wait_drained();
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming,
    // so the block fills up and has to stall its input.
    task automatic test_output_stall();
        block_t res;
        wait_drained();
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        @(posedge clk);
        stall_left = STALL_LEN;
        for (int i = 0; i < 12; i++)
            send_block(cipher_op_t'($urandom_range(1)), word_t'($urandom),
                       word_t'($urandom), res);
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        block_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_blocks.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result %h_%h", rsp_ch.out_left, rsp_ch.out_right);
            end
            else
            begin
                want = pending_blocks.pop_front();
                if (rsp_ch.out_left !== want.left || rsp_ch.out_right !== want.right)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result mismatch: expected %h_%h, got %h_%h",
                                 want.left, want.right, rsp_ch.out_left, rsp_ch.out_right);
                end
            end
        end
    end

    // Watchdog: counts cycles in which nothing moves on any port.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_wen)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("timeout after %0d cycles with no item moving", quiet_cycles);
            $display("** simon32_64_block_cipher_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_wen            = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = OP_ENCRYPT;
        req_ch.block_left  = '0;
        req_ch.block_right = '0;
        rsp_ch.ready       = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_key_patterns();
        test_key_extremes();
        test_random_traffic(160, 8, 69);
        test_random_traffic(160, 69, 8);
        test_random_traffic(160, 0, 0);
        test_output_stall();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_blocks.size() == 0)
            $display("** simon32_64_block_cipher_unit: PASSED **");
        else
            $display("** simon32_64_block_cipher_unit: FAILED **");
        $finish;
    end
endmodule
